>>> rtl/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the utf8 stream decoder
// depends on nothing; used by the interfaces, the decode step and the top level

package utf8d_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CodeWidth  = 31;
   localparam int unsigned CountWidth = 3;

   // lead byte classes: mask and tag pairs
   localparam logic [7:0] AsciiMax   = 8'h7f;
   localparam logic [7:0] Lead2Mask  = 8'he0;
   localparam logic [7:0] Lead2Tag   = 8'hc0;
   localparam logic [7:0] Lead3Mask  = 8'hf0;
   localparam logic [7:0] Lead3Tag   = 8'he0;
   localparam logic [7:0] Lead4Mask  = 8'hf8;
   localparam logic [7:0] Lead4Tag   = 8'hf0;
   localparam logic [7:0] Lead5Mask  = 8'hfc;
   localparam logic [7:0] Lead5Tag   = 8'hf8;
   localparam logic [7:0] Lead6Mask  = 8'hfe;
   localparam logic [7:0] Lead6Tag   = 8'hfc;

   // payload bits kept from each byte kind
   localparam logic [7:0] ContBits   = 8'h3f;
   localparam logic [7:0] Lead2Bits  = 8'h1f;
   localparam logic [7:0] Lead3Bits  = 8'h0f;
   localparam logic [7:0] Lead4Bits  = 8'h07;
   localparam logic [7:0] Lead5Bits  = 8'h03;
   localparam logic [7:0] Lead6Bits  = 8'h01;

   // continuation counts announced by each lead class
   localparam logic [CountWidth-1:0] Cont1 = 3'd1;
   localparam logic [CountWidth-1:0] Cont2 = 3'd2;
   localparam logic [CountWidth-1:0] Cont3 = 3'd3;
   localparam logic [CountWidth-1:0] Cont4 = 3'd4;
   localparam logic [CountWidth-1:0] Cont5 = 3'd5;

   typedef struct packed {
      logic [CountWidth-1:0] bytes_remaining;
      logic [CodeWidth-1:0]  partial_code;
      logic                  stop_flag;
   } dec_state_type;

   typedef struct packed {
      logic                 code_valid;
      logic [CodeWidth-1:0] code_point;
      logic                 string_done;
      logic                 halted;
   } dec_result_type;

endpackage

>>> rtl/utf8d_if.sv
// utf8d_if: valid/ready channel interfaces for the byte input and the result output
// depends on utf8d_pkg for field widths

interface utf8d_req_if;
   logic                              valid;
   logic                              ready;
   logic [utf8d_pkg::ByteWidth-1:0]   data_byte;
   logic                              end_of_string;

   modport source (output valid, output data_byte, output end_of_string, input ready);
   modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface utf8d_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              code_valid;
   logic [utf8d_pkg::CodeWidth-1:0]   code_point;
   logic                              string_done;
   logic                              halted;

   modport source (output valid, output code_valid, output code_point,
                   output string_done, output halted, input ready);
   modport sink   (input valid, input code_valid, input code_point,
                   input string_done, input halted, output ready);
endinterface

>>> rtl/utf8d_step.sv
// utf8d_step: one decode step, combinational, from current state and one byte
// depends on utf8d_pkg for the state and result types and lead byte constants

module utf8d_step (
   input  utf8d_pkg::dec_state_type          state_cur,
   input  logic [utf8d_pkg::ByteWidth-1:0]   data_byte,
   input  logic                              end_of_string,
   output utf8d_pkg::dec_state_type          state_nxt,
   output utf8d_pkg::dec_result_type         result
);

   logic [utf8d_pkg::CountWidth-1:0] lead_count;
   logic [7:0]                       lead_payload;
   logic                             lead_bad;
   logic [utf8d_pkg::CountWidth-1:0] count_dec;
   logic [utf8d_pkg::CodeWidth-1:0]  shifted_code;
   utf8d_pkg::dec_state_type         upd;
   logic                             out_valid;
   logic [utf8d_pkg::CodeWidth-1:0]  out_code;

   // classify a lead byte
   always_comb begin
      lead_count   = '0;
      lead_payload = '0;
      lead_bad     = 1'b0;
      if (data_byte <= utf8d_pkg::AsciiMax) begin
         lead_payload = data_byte;
      end else if ((data_byte & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Tag) begin
         lead_count   = utf8d_pkg::Cont1;
         lead_payload = data_byte & utf8d_pkg::Lead2Bits;
      end else if ((data_byte & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Tag) begin
         lead_count   = utf8d_pkg::Cont2;
         lead_payload = data_byte & utf8d_pkg::Lead3Bits;
      end else if ((data_byte & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Tag) begin
         lead_count   = utf8d_pkg::Cont3;
         lead_payload = data_byte & utf8d_pkg::Lead4Bits;
      end else if ((data_byte & utf8d_pkg::Lead5Mask) == utf8d_pkg::Lead5Tag) begin
         lead_count   = utf8d_pkg::Cont4;
         lead_payload = data_byte & utf8d_pkg::Lead5Bits;
      end else if ((data_byte & utf8d_pkg::Lead6Mask) == utf8d_pkg::Lead6Tag) begin
         lead_count   = utf8d_pkg::Cont5;
         lead_payload = data_byte & utf8d_pkg::Lead6Bits;
      end else begin
         lead_bad = 1'b1;
      end
   end

   // continuation byte: shift six payload bits in
   assign count_dec    = state_cur.bytes_remaining - 3'd1;
   assign shifted_code = {state_cur.partial_code[utf8d_pkg::CodeWidth-7:0],
                          data_byte[5:0] & utf8d_pkg::ContBits[5:0]};

   // state update and code point output
   always_comb begin
      upd       = state_cur;
      out_valid = 1'b0;
      out_code  = '0;
      if (!state_cur.stop_flag) begin
         if (state_cur.bytes_remaining == '0) begin
            if (lead_bad) begin
               upd.stop_flag = 1'b1;
            end else if (lead_count == '0) begin
               out_valid = 1'b1;
               out_code  = {{(utf8d_pkg::CodeWidth-8){1'b0}}, lead_payload};
            end else begin
               upd.bytes_remaining = lead_count;
               upd.partial_code    = {{(utf8d_pkg::CodeWidth-8){1'b0}}, lead_payload};
            end
         end else begin
            upd.bytes_remaining = count_dec;
            if (count_dec == '0) begin
               out_valid        = 1'b1;
               out_code         = shifted_code;
               upd.partial_code = '0;
            end else begin
               upd.partial_code = shifted_code;
            end
         end
         // truncated sequence at the end of the string
         if (end_of_string && upd.bytes_remaining != '0) begin
            upd.stop_flag = 1'b1;
         end
      end
   end

   // result, and fresh state after the final byte
   always_comb begin
      result.code_valid  = out_valid;
      result.code_point  = out_code;
      result.string_done = end_of_string;
      result.halted      = upd.stop_flag;
      state_nxt          = end_of_string ? '0 : upd;
   end

endmodule

>>> rtl/utf8_stream_decoder_top.sv
// utf8_stream_decoder_top: input register, decode step and result register
// depends on utf8d_pkg, utf8d_if (utf8d_req_if, utf8d_rsp_if) and utf8d_step

// Decodes original-form UTF-8 (one to six byte sequences) one byte per item and
// gives exactly one result per byte. Throughput is one byte per clock while the
// result channel is ready. A byte lands in the input register at the edge that
// accepts it and is decoded into the result register once that register is empty
// or being taken; its result is then offered from the result register. The
// decode state (count of bytes still expected, partial code point, halt flag)
// updates as an item moves from the input register to the result register, so
// consecutive bytes chain without a bubble. Continuation bytes are not checked.
// An invalid lead byte or a string that ends inside a sequence sets halted for the
// rest of that string; the byte marked end_of_string returns all state to zero.

module utf8_stream_decoder_top (
   input  logic               clock,
   input  logic               reset,
   utf8d_req_if.sink          req,
   utf8d_rsp_if.source        rsp
);

   logic                              in_vld_ff;
   logic                              in_vld_in;
   logic [utf8d_pkg::ByteWidth-1:0]   in_byte_ff;
   logic                              in_eos_ff;
   logic                              out_vld_ff;
   logic                              out_vld_in;
   utf8d_pkg::dec_result_type         out_res_ff;
   utf8d_pkg::dec_state_type          state_ff;
   utf8d_pkg::dec_state_type          state_in;
   utf8d_pkg::dec_state_type          step_state;
   utf8d_pkg::dec_result_type         step_result;
   logic                              out_free;
   logic                              advance;
   logic                              take;

   // handshake: result register frees when empty or taken
   assign out_free  = !out_vld_ff || rsp.ready;
   assign advance   = in_vld_ff && out_free;
   assign req.ready = !in_vld_ff || out_free;
   assign take      = req.valid && req.ready;

   assign in_vld_in  = take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp.ready);
   assign state_in   = advance ? step_state : state_ff;

   // decode step
   utf8d_step u_step (
      .state_cur     (state_ff),
      .data_byte     (in_byte_ff),
      .end_of_string (in_eos_ff),
      .state_nxt     (step_state),
      .result        (step_result)
   );

   // control and decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         state_ff   <= state_in;
      end
   end

   // input item register
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req.data_byte;
         in_eos_ff  <= req.end_of_string;
      end
   end

   // result item register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= step_result;
      end
   end

   // result channel
   assign rsp.valid       = out_vld_ff;
   assign rsp.code_valid  = out_res_ff.code_valid;
   assign rsp.code_point  = out_res_ff.code_point;
   assign rsp.string_done = out_res_ff.string_done;
   assign rsp.halted      = out_res_ff.halted;

endmodule

>>> verif/utf8_stream_decoder_checker.sv
// utf8_stream_decoder_checker: watches the byte and result channels, predicts each result
// and compares it field by field; depends on utf8d_pkg and utf8d_if
`timescale 1ns / 1ps

module utf8_stream_decoder_checker
   import utf8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   utf8d_req_if        req_ch,
   utf8d_rsp_if        rsp_ch,
   output int unsigned fail_count,
   output int unsigned pending_count,
   output int unsigned result_count,
   output int unsigned code_count,
   output int unsigned halt_count,
   output int unsigned string_count
);

   // decoder state as the block should hold it
   logic [CountWidth-1:0] cont_left;
   logic [CodeWidth-1:0]  code_acc;
   logic                  halt_seen;

   dec_result_type pending_results[$];
   int unsigned    fails;
   int unsigned    checked;
   int unsigned    codes;
   int unsigned    halts;
   int unsigned    strings;

   initial begin
      fails         = 0;
      checked       = 0;
      codes         = 0;
      halts         = 0;
      strings       = 0;
   end

   // one decode step: updates the state and gives the result for this byte
   function automatic dec_result_type decode_next(input logic [7:0] in_byte,
                                                  input logic       last_byte);
      dec_result_type        res;
      logic [CodeWidth-1:0]  lead_bits;
      logic [CountWidth-1:0] lead_cont;
      res             = '0;
      res.string_done = last_byte;
      if (!halt_seen) begin
         if (cont_left == '0) begin
            lead_bits = '0;
            lead_cont = '0;
            if (in_byte <= AsciiMax) begin
               res.code_valid = 1'b1;
               res.code_point = CodeWidth'(in_byte);
            end else if ((in_byte & Lead2Mask) == Lead2Tag) begin
               lead_cont = Cont1;
               lead_bits = CodeWidth'(in_byte & Lead2Bits);
            end else if ((in_byte & Lead3Mask) == Lead3Tag) begin
               lead_cont = Cont2;
               lead_bits = CodeWidth'(in_byte & Lead3Bits);
            end else if ((in_byte & Lead4Mask) == Lead4Tag) begin
               lead_cont = Cont3;
               lead_bits = CodeWidth'(in_byte & Lead4Bits);
            end else if ((in_byte & Lead5Mask) == Lead5Tag) begin
               lead_cont = Cont4;
               lead_bits = CodeWidth'(in_byte & Lead5Bits);
            end else if ((in_byte & Lead6Mask) == Lead6Tag) begin
               lead_cont = Cont5;
               lead_bits = CodeWidth'(in_byte & Lead6Bits);
            end else begin
               // stray continuation byte, 0xfe or 0xff in lead position
               halt_seen = 1'b1;
            end
            cont_left = lead_cont;
            code_acc  = lead_bits;
         end else begin
            // continuation bytes are taken unchecked, low six bits only
            code_acc  = {code_acc[CodeWidth-7:0], 6'(in_byte & ContBits)};
            cont_left = cont_left - 1'b1;
            if (cont_left == '0) begin
               res.code_valid = 1'b1;
               res.code_point = code_acc;
               code_acc       = '0;
            end
         end
         // string ends inside a sequence
         if (last_byte && cont_left != '0)
            halt_seen = 1'b1;
      end
      res.halted = halt_seen;
      if (last_byte) begin
         cont_left = '0;
         code_acc  = '0;
         halt_seen = 1'b0;
      end
      return res;
   endfunction

   // predict on each accepted byte, compare on each accepted result
   always @(posedge clock) begin
      dec_result_type want;
      dec_result_type got;
      if (reset) begin
         cont_left = '0;
         code_acc  = '0;
         halt_seen = 1'b0;
         pending_results.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            pending_results.insert(pending_results.size(),
                                   decode_next(req_ch.data_byte, req_ch.end_of_string));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.code_valid  = rsp_ch.code_valid;
            got.code_point  = rsp_ch.code_point;
            got.string_done = rsp_ch.string_done;
            got.halted      = rsp_ch.halted;
            checked++;
            if (pending_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display({"unexpected result %0d with no byte pending: ",
                            "valid=%0b code=%h done=%0b halted=%0b"},
                           checked, got.code_valid, got.code_point, got.string_done,
                           got.halted);
            end else begin
               want = pending_results.pop_front();
               if (got.code_valid !== want.code_valid || got.code_point !== want.code_point ||
                   got.string_done !== want.string_done || got.halted !== want.halted) begin
                  fails++;
                  if (fails <= 10)
                     $display({"mismatch on result %0d: ",
                               "expected valid=%0b code=%h done=%0b halted=%0b, ",
                               "got valid=%0b code=%h done=%0b halted=%0b"},
                              checked, want.code_valid, want.code_point, want.string_done,
                              want.halted, got.code_valid, got.code_point, got.string_done,
                              got.halted);
               end
               if (want.code_valid)
                  codes++;
               if (want.halted)
                  halts++;
               if (want.string_done)
                  strings++;
            end
         end
      end
      fail_count    <= fails;
      pending_count <= pending_results.size();
      result_count  <= checked;
      code_count    <= codes;
      halt_count    <= halts;
      string_count  <= strings;
   end

endmodule

>>> verif/utf8_stream_decoder_top_test.sv
// utf8_stream_decoder_top_test: clock, reset, byte stimulus with bursts and result stalls
// depends on utf8d_pkg, utf8d_if, utf8_stream_decoder_top and utf8_stream_decoder_checker
`timescale 1ns / 1ps

module utf8_stream_decoder_top_test;
   import utf8d_pkg::*;

   localparam int unsigned RandomItems = 700;
   localparam int unsigned DrainCycles = 20;
   localparam int unsigned CycleLimit  = 200000;

   typedef enum int unsigned {
      ReadyAlways,
      ReadyCoin,
      ReadyTwoOfThree,
      ReadyRare
   } ready_mode_type;

   logic        clock;
   logic        reset = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned burst_left = 0;
   logic [7:0]  str_bytes[$];

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned result_count;
   int unsigned code_count;
   int unsigned halt_count;
   int unsigned string_count;

   utf8d_req_if req_ch ();
   utf8d_rsp_if rsp_ch ();

   utf8_stream_decoder_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   utf8_stream_decoder_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .code_count    (code_count),
      .halt_count    (halt_count),
      .string_count  (string_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles with %0d results pending", cycle_count, pending_count);
         $display("utf8_stream_decoder_top test failed");
         $finish;
      end
   end

   // result side stalls, switching pattern every so often
   initial begin
      ready_mode_type ready_mode;
      int unsigned    mode_left;
      int unsigned    phase;
      ready_mode = ReadyAlways;
      mode_left  = 40;
      phase      = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 150);
         end else begin
            mode_left--;
         end
         phase++;
         case (ready_mode)
            ReadyAlways:     rsp_ch.ready <= 1'b1;
            ReadyCoin:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            ReadyTwoOfThree: rsp_ch.ready <= (phase % 3 != 0);
            default:         rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // append one byte to the string being built
   function automatic void add_byte(input logic [7:0] value);
      str_bytes.insert(str_bytes.size(), value);
   endfunction

   // send str_bytes as one string, end mark on the last item, gaps between bursts
   task automatic send_string();
      int unsigned idx;
      for (idx = 0; idx < str_bytes.size(); idx++) begin
         req_ch.valid         <= 1'b1;
         req_ch.data_byte     <= str_bytes[idx];
         req_ch.end_of_string <= (idx == str_bytes.size() - 1);
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         bytes_sent++;
         if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   initial begin
      int unsigned random_start;
      int unsigned kind;
      int unsigned n_codes;
      int unsigned bad_at;
      int unsigned len;
      int unsigned keep;
      int unsigned pick;
      int unsigned c;
      logic [7:0]  lead;
      req_ch.valid         <= 1'b0;
      req_ch.data_byte     <= '0;
      req_ch.end_of_string <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst_left = $urandom_range(0, 12);

      // every sequence length at its largest payload, ascii extremes first
      str_bytes = '{8'h00, 8'h7f, 8'hdf, 8'hbf, 8'hef, 8'hbf, 8'hbf,
                    8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'hfb, 8'hbf, 8'hbf, 8'hbf, 8'hbf,
                    8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf};
      send_string();
      // invalid lead byte, then a byte while halted
      str_bytes = '{8'hff, 8'h41};
      send_string();
      // string ends on a multi-byte lead byte
      str_bytes = '{8'he0};
      send_string();
      // string ends inside a sequence
      str_bytes = '{8'hf0, 8'h80};
      send_string();

      // random strings: mostly well formed, some truncated, some with a bad lead, some noise
      random_start = bytes_sent;
      while (bytes_sent - random_start < RandomItems) begin
         str_bytes.delete();
         kind    = $urandom_range(0, 99);
         n_codes = $urandom_range(1, 8);
         bad_at  = $urandom_range(0, n_codes - 1);
         if (kind >= 92) begin
            repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
         end else begin
            for (c = 0; c < n_codes; c++) begin
               // invalid lead in place of a code point start
               if (kind >= 76 && kind < 84 && c == bad_at) begin
                  case ($urandom_range(0, 3))
                     0:       add_byte(8'hfe);
                     1:       add_byte(8'hff);
                     default: add_byte(8'h80 | 8'($urandom_range(0, 63)));
                  endcase
               end
               pick = $urandom_range(0, 99);
               if (pick < 40)
                  len = 1;
               else if (pick < 60)
                  len = 2;
               else if (pick < 75)
                  len = 3;
               else if (pick < 87)
                  len = 4;
               else if (pick < 94)
                  len = 5;
               else
                  len = 6;
               keep = len - 1;
               // last sequence cut short by the end of the string
               if (kind >= 84 && c == n_codes - 1) begin
                  if (len == 1)
                     len = $urandom_range(2, 6);
                  keep = $urandom_range(0, len - 2);
               end
               lead = 8'($urandom);
               case (len)
                  1:       lead = lead & AsciiMax;
                  2:       lead = (lead & Lead2Bits) | Lead2Tag;
                  3:       lead = (lead & Lead3Bits) | Lead3Tag;
                  4:       lead = (lead & Lead4Bits) | Lead4Tag;
                  5:       lead = (lead & Lead5Bits) | Lead5Tag;
                  default: lead = (lead & Lead6Bits) | Lead6Tag;
               endcase
               add_byte(lead);
               // continuation bytes, now and then with arbitrary top bits
               repeat (keep) begin
                  if ($urandom_range(0, 9) == 0)
                     add_byte(8'($urandom));
                  else
                     add_byte(8'h80 | 8'($urandom_range(0, 63)));
               end
            end
         end
         send_string();
      end
      req_ch.valid <= 1'b0;

      // drain: one edge first so the count includes the last byte sent
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("sent %0d bytes in %0d strings; %0d results checked, %0d code points decoded",
               bytes_sent, string_count, result_count, code_count);
      $display("%0d results came back halted, %0d mismatches", halt_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("utf8_stream_decoder_top test passed");
      end else begin
         $display("utf8_stream_decoder_top test failed");
      end
      $finish;
   end

endmodule

>>> utf8_stream_decoder_top.f
rtl/utf8d_pkg.sv
rtl/utf8d_if.sv
rtl/utf8d_step.sv
rtl/utf8_stream_decoder_top.sv
verif/utf8_stream_decoder_checker.sv
verif/utf8_stream_decoder_top_test.sv
